// ===== design/mtt_pkg.sv =====
package mtt_pkg;

  localparam int NUM_CODES   = 36;
  localparam int NUM_LETTERS = 26;
  localparam int MAX_SYMBOLS = 5;
  localparam int MAX_RESULTS = 6;

  typedef logic [7:0] char_t;
  typedef logic [2:0] count_t;
  typedef logic [4:0] sym_bits_t;

  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_QMARK = 8'h3F;
  localparam char_t CH_UA    = 8'h41;
  localparam char_t CH_UZ    = 8'h5A;
  localparam char_t CH_LA    = 8'h61;
  localparam char_t CH_LZ    = 8'h7A;
  localparam char_t CASE_GAP = 8'h20;

  localparam count_t CODE_LEN [NUM_CODES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam sym_bits_t CODE_BITS [NUM_CODES] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
    5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3,
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  typedef struct packed {
    count_t                       len;
    logic                         unk;
    logic [MAX_RESULTS-1:0][7:0]  chars;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic char_t code_char(input logic [5:0] idx);
    char_t r;
    if (idx < 6'(NUM_LETTERS)) begin
      r = CH_UA + 8'(idx);
    end else begin
      r = CH_ZERO + 8'(idx - 6'(NUM_LETTERS));
    end
    return r;
  endfunction

  // bit 8 set on a hit, low byte is the character
  function automatic logic [8:0] decode_lookup(input count_t n, input sym_bits_t bits);
    sym_bits_t  mask;
    logic [8:0] r;
    mask = 5'((6'd1 << n) - 6'd1);
    r = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if (CODE_LEN[i] == n && ((CODE_BITS[i] ^ bits) & mask) == 5'd0) begin
        r = {1'b1, code_char(6'(i))};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/mtt_in_if.sv =====
interface mtt_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

// ===== design/mtt_out_if.sv =====
interface mtt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        unknown_code;
  logic        last;

  modport source (output valid, output out_char, output unknown_code, output last,
                  input ready);
  modport sink   (input valid, input out_char, input unknown_code, input last,
                  output ready);
endinterface

// ===== design/morse_text_transcoder.sv =====
// Morse text transcoder: one ASCII character in per item, a run of result characters
// out (dots, dashes, separators, CR LF, or a decoded letter/digit, '?' flagged by
// unknown_code), with last marking the final result of each item. The input side
// takes one item per cycle as long as the job queue (QUEUE_DEPTH entries) has room;
// an item that yields nothing never enters the queue. The output side sends one
// result per cycle while dout.ready is high, with up to six results for a digit.
// Sustained rate is therefore set by the output port, and items with no results
// never take the output at all.
module morse_text_transcoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  mtt_in_if.sink     din,
  mtt_out_if.source  dout
);
  import mtt_pkg::*;

  q_wr_t   q_wr;
  q_rd_t   q_rd;
  q_stat_t q_stat;
  logic    pop;

  mtt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .din    (din),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  mtt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_rd   (q_rd),
    .q_stat (q_stat)
  );

  mtt_back u_back (
    .clk  (clk),
    .rst  (rst),
    .q_rd (q_rd),
    .pop  (pop),
    .dout (dout)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_stat.full)
    else $error("job pushed into full queue");

  a_pushed_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> (q_wr.job.len != 3'd0 && q_wr.job.len <= 3'(MAX_RESULTS)))
    else $error("job length out of range");

  a_unknown_is_qmark: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.unknown_code) |-> (dout.out_char == CH_QMARK && dout.last))
    else $error("unknown_code on a result other than a lone '?'");

  a_idle_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !dout.valid)
    else $error("output valid right after reset");

endmodule

// ===== design/mtt_front.sv =====
module mtt_front (
  input  logic           clk,
  input  logic           rst,
  mtt_in_if.sink         din,
  input  mtt_pkg::q_stat_t q_stat,
  output mtt_pkg::q_wr_t   q_wr
);
  import mtt_pkg::*;

  logic      decode_mode, decode_mode_next;
  count_t    symbol_count, symbol_count_next;
  sym_bits_t symbol_bits, symbol_bits_next;

  char_t      c;
  logic       is_letter, is_digit, is_sym, accept;
  logic [5:0] idx;
  count_t     enc_len;
  sym_bits_t  enc_bits;
  logic [8:0] dec;
  job_t       job;

  assign din.ready = !q_stat.full;
  assign accept    = din.valid && din.ready;

  always_comb begin
    c = din.in_char;
    if (c >= CH_LA && c <= CH_LZ) c = c - CASE_GAP;
    is_letter = (c >= CH_UA && c <= CH_UZ);
    is_digit  = (c >= CH_ZERO && c <= CH_NINE);
    is_sym    = (c == CH_DOT || c == CH_DASH);
    idx       = is_digit ? 6'(c - CH_ZERO) + 6'(NUM_LETTERS) : 6'(c - CH_UA);
    enc_len   = CODE_LEN[idx];
    enc_bits  = CODE_BITS[idx];
    dec       = decode_lookup(symbol_count, symbol_bits);
  end

  always_comb begin
    decode_mode_next  = decode_mode;
    symbol_count_next = symbol_count;
    symbol_bits_next  = symbol_bits;
    job               = '0;
    if (is_letter || is_digit) begin
      decode_mode_next = 1'b0;
    end else if (is_sym) begin
      decode_mode_next = 1'b1;
    end
    if (c == CH_CR) begin
      job.chars[0] = CH_CR;
      job.chars[1] = CH_LF;
      job.len      = 3'd2;
    end
    if (decode_mode_next) begin
      priority if (is_sym) begin
        if (symbol_count < 3'(MAX_SYMBOLS)) begin
          symbol_bits_next[symbol_count] = (c == CH_DASH);
          symbol_count_next = symbol_count + 3'd1;
        end
      end else if (c == CH_SPACE || c == CH_SLASH) begin
        if (symbol_count == 3'd0) begin
          if (c == CH_SLASH) begin
            job.chars[0] = CH_SPACE;
            job.len      = 3'd1;
          end
        end else if (dec[8]) begin
          job.chars[0] = dec[7:0];
          job.chars[1] = CH_SPACE;
          job.len      = (c == CH_SLASH) ? 3'd2 : 3'd1;
        end else begin
          job.chars[0] = CH_QMARK;
          job.unk      = 1'b1;
          job.len      = 3'd1;
        end
        symbol_count_next = '0;
      end else begin
        symbol_count_next = '0;
      end
    end else begin
      if (is_letter || is_digit) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
          if (3'(k) < enc_len) begin
            job.chars[k] = enc_bits[k % MAX_SYMBOLS] ? CH_DASH : CH_DOT;
          end else if (3'(k) == enc_len) begin
            job.chars[k] = CH_SPACE;
          end
        end
        job.len = enc_len + 3'd1;
      end else if (c == CH_SPACE) begin
        job.chars[0] = CH_SLASH;
        job.chars[1] = CH_SPACE;
        job.len      = 3'd2;
      end
    end
  end

  assign q_wr.push = accept && (job.len != 3'd0);
  assign q_wr.job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode  <= 1'b0;
      symbol_count <= '0;
      symbol_bits  <= '0;
    end else if (accept) begin
      decode_mode  <= decode_mode_next;
      symbol_count <= symbol_count_next;
      symbol_bits  <= symbol_bits_next;
    end
  end

endmodule

// ===== design/mtt_queue.sv =====
module mtt_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  mtt_pkg::q_wr_t   q_wr,
  input  logic             pop,
  output mtt_pkg::q_rd_t   q_rd,
  output mtt_pkg::q_stat_t q_stat
);
  import mtt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push, do_pop;

  assign q_stat.full  = (level == LVL_W'(DEPTH));
  assign q_stat.empty = (level == '0);
  assign do_push      = q_wr.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign q_rd.valid   = !q_stat.empty;
  assign q_rd.job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= q_wr.job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ===== design/mtt_back.sv =====
module mtt_back (
  input  logic           clk,
  input  logic           rst,
  input  mtt_pkg::q_rd_t q_rd,
  output logic           pop,
  mtt_out_if.source      dout
);
  import mtt_pkg::*;

  logic   busy, ovalid, ounk, olast;
  char_t  ochar;
  job_t   job, cur_job;
  count_t pos, cur_pos;
  logic   have, adv, is_last;

  assign adv     = !ovalid || dout.ready;
  assign have    = busy || q_rd.valid;
  assign cur_job = busy ? job : q_rd.job;
  assign cur_pos = busy ? pos : 3'd0;
  assign is_last = (cur_pos == cur_job.len - 3'd1);
  assign pop     = adv && !busy && q_rd.valid;

  assign dout.valid        = ovalid;
  assign dout.out_char     = ochar;
  assign dout.unknown_code = ounk;
  assign dout.last         = olast;

  always_ff @(posedge clk) begin
    if (adv && have) begin
      ochar <= cur_job.chars[cur_pos];
      ounk  <= cur_job.unk;
      olast <= is_last;
      job   <= cur_job;
      pos   <= cur_pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else if (adv) begin
      ovalid <= have;
      busy   <= have && !is_last;
    end
  end

endmodule
